[src/secv_pkg.sv]
// ----------------------------------------------------------------------------
// secv_pkg : shared types and constants for the circular vignette core
// Register indexes, pixel classes and the arithmetic step functions used by
// the square-root and divider pipelines.
// ----------------------------------------------------------------------------
`default_nettype none
package secv_pkg;

	localparam int REG_W = 16;
	localparam int COORD_W = 12;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_OUTER_R = 2'd2;
	localparam logic [IDX_W-1:0] REG_INNER_R = 2'd3;

	// square root: 52-bit radicand, 26 result bits, two bits per stage
	localparam int RAD_W = 52;
	localparam int ROOT_W = 26;
	localparam int REM_W = 30;
	localparam int SQ_STAGES = 13;

	// divider: 16 quotient bits, two bits per stage
	localparam int DEN_W = 24;
	localparam int QUO_W = 16;
	localparam int DV_STAGES = 8;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_PASS = 2'd1,
		CLS_BAND = 2'd2
	} cls_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sq_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] quot;
	} dv_t;

	function automatic sq_t sqrt_step(sq_t a);
		sq_t r;
		logic [REM_W-1:0] rem_n;
		logic [REM_W:0]   trial;
		rem_n = {a.rem[REM_W-3:0], a.rad[RAD_W-1:RAD_W-2]};
		trial = {1'b0, rem_n} - {{(REM_W-ROOT_W-1){1'b0}}, a.root, 2'b01};
		r.rad = {a.rad[RAD_W-3:0], 2'b00};
		if (!trial[REM_W]) begin
			r.rem = trial[REM_W-1:0];
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem = rem_n;
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic dv_t div_step(dv_t a, logic [DEN_W-1:0] den);
		dv_t r;
		logic [DEN_W:0] r2;
		r2 = {a.rem, 1'b0};
		if (r2 >= {1'b0, den}) begin
			r.rem = DEN_W'(r2 - {1'b0, den});
			r.quot = {a.quot[QUO_W-2:0], 1'b1};
		end else begin
			r.rem = r2[DEN_W-1:0];
			r.quot = {a.quot[QUO_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[src/soft_edge_circular_vignette_core.sv]
// ----------------------------------------------------------------------------
// soft_edge_circular_vignette_core : circular vignette mask, pipelined
// Scales each pixel by 1-((d-ri)/(R-ri))^2 between inner and outer radius.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------
//  input     | start / busy       | pixel_value, column, row_index
//  result    | done (strobe)      | pixel_out
//  config    | wr_en              | wr_index, wr_data
//
// One transaction per cycle.
// The pipeline includes the 13-stage square root and the 8-stage divider.
// busy is always low; the receiver cannot stall, so nothing is held.
// Reset clears the configuration registers and all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
module soft_edge_circular_vignette_core #(
	parameter int MAX_SIZE = 4096,
	parameter int PIXEL_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [PIXEL_BITS-1:0]           pixel_value,
	input  wire logic [secv_pkg::COORD_W-1:0]    column,
	input  wire logic [secv_pkg::COORD_W-1:0]    row_index,
	output logic                                 done,
	output logic [PIXEL_BITS-1:0]                pixel_out,
	input  wire logic                            wr_en,
	input  wire logic [secv_pkg::IDX_W-1:0]      wr_index,
	input  wire logic [secv_pkg::REG_W-1:0]      wr_data
);
	import secv_pkg::*;

	localparam int LAT = 29;

	typedef struct packed {
		cls_t                  cls;
		logic [PIXEL_BITS-1:0] pix;
	} ctl_t;

	logic [REG_W-1:0] cx_q, cy_q, ro_q, ri_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			ro_q <= '0;
			ri_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CENTER_X: cx_q <= wr_data;
				REG_CENTER_Y: cy_q <= wr_data;
				REG_OUTER_R:  ro_q <= wr_data;
				REG_INNER_R:  ri_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: offsets
	ctl_t ctl_in, ctl_s1, ctl_s2, ctl_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic [REG_W-1:0] dx_s1, dy_s1;
	logic [REG_W-1:0] cx16, cy16;
	logic oob;

	assign cx16 = {column, 4'b0};
	assign cy16 = {row_index, 4'b0};
	assign oob = (32'(column) >= 32'(MAX_SIZE)) || (32'(row_index) >= 32'(MAX_SIZE));

	always_comb begin
		ctl_in.pix = pixel_value;
		if (oob) ctl_in.cls = CLS_ZERO;
		else if (ri_q == '0) ctl_in.cls = CLS_PASS;
		else ctl_in.cls = CLS_BAND;
	end

	// stage 2: squares; stage 3: sum and radius tests
	logic [2*REG_W-1:0] dxx_s2, dyy_s2, r2_s2, ri2_s2;
	logic [2*REG_W:0]   ssum;
	sq_t                sq_s3;
	cls_t               cls3;

	assign ssum = {1'b0, dxx_s2} + {1'b0, dyy_s2};

	always_comb begin
		cls3 = ctl_s2.cls;
		if (ctl_s2.cls == CLS_BAND) begin
			if (ssum > {1'b0, r2_s2}) cls3 = CLS_ZERO;
			else if (ssum < {1'b0, ri2_s2}) cls3 = CLS_PASS;
			else if (ro_q <= ri_q) cls3 = CLS_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1.cls <= ctl_in.cls;
		ctl_s1.pix <= ctl_in.pix;
		dx_s1 <= (cx16 >= cx_q) ? cx16 - cx_q : cx_q - cx16;
		dy_s1 <= (cy16 >= cy_q) ? cy16 - cy_q : cy_q - cy16;
		ctl_s2.cls <= ctl_s1.cls;
		ctl_s2.pix <= ctl_s1.pix;
		dxx_s2 <= dx_s1 * dx_s1;
		dyy_s2 <= dy_s1 * dy_s1;
		r2_s2 <= ro_q * ro_q;
		ri2_s2 <= ri_q * ri_q;
		ctl_s3.cls <= cls3;
		ctl_s3.pix <= ctl_s2.pix;
		sq_s3.rem <= '0;
		sq_s3.root <= '0;
		sq_s3.rad <= {{(RAD_W-2*REG_W-17){1'b0}}, ssum, 16'b0};
	end

	// square-root pipeline, two result bits per stage
	ctl_t ctl_sq_s [SQ_STAGES];
	logic vld_sq_s [SQ_STAGES];
	sq_t  sq_s     [SQ_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQ_STAGES; k++) vld_sq_s[k] <= 1'b0;
		end else begin
			vld_sq_s[0] <= vld_s3;
			for (int k = 1; k < SQ_STAGES; k++) vld_sq_s[k] <= vld_sq_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		ctl_sq_s[0].cls <= ctl_s3.cls;
		ctl_sq_s[0].pix <= ctl_s3.pix;
		sq_s[0] <= sqrt_step(sqrt_step(sq_s3));
		for (int k = 1; k < SQ_STAGES; k++) begin
			ctl_sq_s[k].cls <= ctl_sq_s[k-1].cls;
			ctl_sq_s[k].pix <= ctl_sq_s[k-1].pix;
			sq_s[k] <= sqrt_step(sqrt_step(sq_s[k-1]));
		end
	end

	// divider set-up
	logic [ROOT_W-1:0] dval, ri12, tval;
	logic [DEN_W-1:0]  den;
	ctl_t              ctl_dp_s;
	logic              vld_dp_s;
	logic              ge_dp_s;
	dv_t               dv_dp_s;

	assign dval = sq_s[SQ_STAGES-1].root;
	assign ri12 = {2'b0, ri_q, 8'b0};
	assign den = {ro_q - ri_q, 8'b0};
	assign tval = (dval > ri12) ? dval - ri12 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_dp_s <= 1'b0;
		else vld_dp_s <= vld_sq_s[SQ_STAGES-1];
	end

	always_ff @(posedge clk) begin
		ctl_dp_s.cls <= ctl_sq_s[SQ_STAGES-1].cls;
		ctl_dp_s.pix <= ctl_sq_s[SQ_STAGES-1].pix;
		ge_dp_s <= tval >= {2'b0, den};
		dv_dp_s.rem <= tval[DEN_W-1:0];
		dv_dp_s.quot <= '0;
	end

	// restoring divider, two quotient bits per stage
	ctl_t ctl_dv_s [DV_STAGES];
	logic vld_dv_s [DV_STAGES];
	logic ge_dv_s  [DV_STAGES];
	dv_t  dv_s     [DV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DV_STAGES; k++) vld_dv_s[k] <= 1'b0;
		end else begin
			vld_dv_s[0] <= vld_dp_s;
			for (int k = 1; k < DV_STAGES; k++) vld_dv_s[k] <= vld_dv_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		ctl_dv_s[0].cls <= ctl_dp_s.cls;
		ctl_dv_s[0].pix <= ctl_dp_s.pix;
		ge_dv_s[0] <= ge_dp_s;
		dv_s[0] <= div_step(div_step(dv_dp_s, den), den);
		for (int k = 1; k < DV_STAGES; k++) begin
			ctl_dv_s[k].cls <= ctl_dv_s[k-1].cls;
			ctl_dv_s[k].pix <= ctl_dv_s[k-1].pix;
			ge_dv_s[k] <= ge_dv_s[k-1];
			dv_s[k] <= div_step(div_step(dv_s[k-1], den), den);
		end
	end

	// factor and product
	logic [16:0]            qv;
	ctl_t                   ctl_m1_s, ctl_m2_s, ctl_m3_s;
	logic                   vld_m1_s, vld_m2_s, vld_m3_s;
	logic [33:0]            qq_m1_s;
	logic [16:0]            c_m2_s;
	logic [PIXEL_BITS+16:0] prod_m3_s;

	assign qv = ge_dv_s[DV_STAGES-1] ? ONE_Q16 : {1'b0, dv_s[DV_STAGES-1].quot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1_s <= 1'b0;
			vld_m2_s <= 1'b0;
			vld_m3_s <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_m1_s <= vld_dv_s[DV_STAGES-1];
			vld_m2_s <= vld_m1_s;
			vld_m3_s <= vld_m2_s;
			done <= vld_m3_s;
		end
	end

	always_ff @(posedge clk) begin
		ctl_m1_s.cls <= ctl_dv_s[DV_STAGES-1].cls;
		ctl_m1_s.pix <= ctl_dv_s[DV_STAGES-1].pix;
		qq_m1_s <= qv * qv;
		ctl_m2_s.cls <= ctl_m1_s.cls;
		ctl_m2_s.pix <= ctl_m1_s.pix;
		c_m2_s <= ONE_Q16 - qq_m1_s[32:16];
		ctl_m3_s.cls <= ctl_m2_s.cls;
		ctl_m3_s.pix <= ctl_m2_s.pix;
		prod_m3_s <= ctl_m2_s.pix * c_m2_s;
		case (ctl_m3_s.cls)
			CLS_PASS: pixel_out <= ctl_m3_s.pix;
			CLS_BAND: pixel_out <= prod_m3_s[PIXEL_BITS+15:16];
			default:  pixel_out <= '0;
		endcase
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without matching transaction");

	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("transaction lost in pipeline");

	a_oob: assert property (@(posedge clk) disable iff (!arst_n)
		(start && oob) |-> ##LAT (pixel_out == '0))
		else $error("out-of-image pixel not zeroed");

	a_cls: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && ctl_s3.cls == CLS_BAND) |-> (sq_s3.rad[15:0] == '0))
		else $error("radicand misaligned");

endmodule
`default_nettype wire
